### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the two-state plant model
// Word formats, command codes, coefficient layout and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int unsigned DataW      = 32;
    localparam int unsigned ProdW      = 2 * DataW;
    localparam int unsigned ModeW      = 3;
    localparam int unsigned NumCoefs   = 8;
    localparam int unsigned CoefIdxW   = 3;
    localparam int unsigned NumOpds    = 4;
    localparam int unsigned OpdIdxW    = 2;
    localparam int unsigned RowTerms   = 4;
    localparam int unsigned FracShift  = 30;

    typedef logic signed [DataW-1:0] t_word;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef t_word t_coef_bank [NumCoefs];
    typedef t_prod t_prod_bank [NumCoefs];
    typedef t_prod t_row_prods [RowTerms];

    typedef enum logic [ModeW-1:0] {
        MODE_TICK        = 3'd0,
        MODE_LOAD_TORQUE = 3'd1,
        MODE_RESET       = 3'd2,
        MODE_START       = 3'd3,
        MODE_STOP        = 3'd4
    } t_mode;

    // coefficient register indexes
    localparam int unsigned CoefA00 = 0;
    localparam int unsigned CoefA01 = 1;
    localparam int unsigned CoefA10 = 2;
    localparam int unsigned CoefA11 = 3;
    localparam int unsigned CoefB00 = 4;
    localparam int unsigned CoefB01 = 5;
    localparam int unsigned CoefB10 = 6;
    localparam int unsigned CoefB11 = 7;

    // operand indexes
    localparam int unsigned OpdAngle  = 0;
    localparam int unsigned OpdRate   = 1;
    localparam int unsigned OpdTorque = 2;
    localparam int unsigned OpdRel    = 3;

    localparam int unsigned OperandSel [NumCoefs] = '{
        OpdAngle, OpdRate, OpdAngle, OpdRate,
        OpdTorque, OpdRel, OpdTorque, OpdRel
    };

    localparam t_word CoefReset [NumCoefs] = '{
        32'sd1076963049, 32'sd21496311, 32'sd339946661, 32'sd1076963049,
        -32'sd266611, 32'sd3350074, -32'sd26682484, 32'sd335222197
    };

    localparam t_word FallLimit    = 32'sd26340229;
    localparam t_word FallLimitNeg = -32'sd26340229;

endpackage

### src/tsp_cmd_if.sv
// ----------------------------------------------------------------------------
// tsp_cmd_if: command channel
// Valid/ready channel carrying one plant command per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsp_cmd_if
    import tsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ModeW-1:0] mode;
    t_word            torque_value;
    t_word            user_angle;

    modport source (output valid, output mode, output torque_value, output user_angle,
                    input ready);
    modport sink   (input valid, input mode, input torque_value, input user_angle,
                    output ready);
endinterface

### src/tsp_res_if.sv
// ----------------------------------------------------------------------------
// tsp_res_if: result channel
// Valid/ready channel carrying one new plant state per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsp_res_if
    import tsp_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word angle_out;
    t_word rate_out;
    logic  fell;

    modport source (output valid, output angle_out, output rate_out, output fell,
                    input ready);
    modport sink   (input valid, input angle_out, input rate_out, input fell,
                    output ready);
endinterface

### src/tsp_coef_regs.sv
// ----------------------------------------------------------------------------
// tsp_coef_regs: coefficient register bank
// Eight Q2.30 state and input matrix entries, written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_coef_regs
    import tsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CoefIdxW-1:0] i_cfg_index,
    input  t_word               i_cfg_data,
    output t_coef_bank          o_coefs
);

    t_coef_bank r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= CoefReset;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_coefs = r_coef;

endmodule

### src/tsp_mul_stage.sv
// ----------------------------------------------------------------------------
// tsp_mul_stage: product stage
// Forms the relative angle and the eight coefficient products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_mul_stage
    import tsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_load,
    input  t_coef_bank i_coefs,
    input  t_word      i_angle,
    input  t_word      i_rate,
    input  t_word      i_torque,
    input  t_word      i_user_angle,
    output t_prod_bank o_prod
);

    logic [DataW:0] w_diff;
    t_word          w_rel;
    t_word          w_opd [NumOpds];
    t_prod_bank     n_prod;
    t_prod_bank     r_prod;

    // saturate user angle minus tilt angle
    always_comb begin
        w_diff = {i_user_angle[DataW-1], i_user_angle} - {i_angle[DataW-1], i_angle};
        if (w_diff[DataW] != w_diff[DataW-1]) begin
            w_rel = w_diff[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        end else begin
            w_rel = w_diff[DataW-1:0];
        end
    end

    assign w_opd[OpdAngle]  = i_angle;
    assign w_opd[OpdRate]   = i_rate;
    assign w_opd[OpdTorque] = i_torque;
    assign w_opd[OpdRel]    = w_rel;

    for (genvar g = 0; g < NumCoefs; g++) begin : g_mul
        t_word w_a;
        t_word w_b;
        assign w_a       = i_coefs[g];
        assign w_b       = w_opd[OpdIdxW'(OperandSel[g])];
        assign n_prod[g] = w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### src/tsp_row_sum.sv
// ----------------------------------------------------------------------------
// tsp_row_sum: row reduction
// Sums four products exactly, rounds half up to Q8.24 and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_row_sum
    import tsp_pkg::*;
(
    input  t_row_prods i_prod,
    output t_word      o_sum
);

    localparam int unsigned AccW   = ProdW + 2;
    localparam int unsigned ShiftW = AccW - FracShift;

    logic signed [AccW-1:0]   w_acc;
    logic signed [ShiftW-1:0] w_shift;
    logic                     w_fits;

    always_comb begin
        w_acc = AccW'(i_prod[0]) + AccW'(i_prod[1]) + AccW'(i_prod[2]) + AccW'(i_prod[3])
              + (AccW'(1) <<< (FracShift - 1));
        w_shift = w_acc[AccW-1:FracShift];
        w_fits  = (w_shift[ShiftW-1:DataW-1] == '0) || (w_shift[ShiftW-1:DataW-1] == '1);
        if (w_fits) begin
            o_sum = w_shift[DataW-1:0];
        end else if (w_shift[ShiftW-1]) begin
            o_sum = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(DataW-1){1'b1}}};
        end
    end

endmodule

### src/two_state_plant_model_step.sv
// ----------------------------------------------------------------------------
// two_state_plant_model_step: two-state balancing plant, one command per transfer
// A tick result passes from the stage-one register through the product stage to the
// output register. Throughput: one command per cycle unless held back by the result
// channel or because a tick waits while an earlier command is still in the second stage.
// Reset (synchronous): state and run flag clear, coefficients reload, pipeline empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_state_plant_model_step
    import tsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CoefIdxW-1:0] i_cfg_index,
    input  t_word               i_cfg_data,
    tsp_cmd_if.sink             i_cmd,
    tsp_res_if.source           o_res
);

    t_coef_bank w_coefs;
    t_prod_bank w_prod;
    t_row_prods w_row0_prods;
    t_row_prods w_row1_prods;
    t_word      w_new_angle;
    t_word      w_new_rate;
    logic       w_fall;

    logic             r_s1_valid;
    logic [ModeW-1:0] r_s1_mode;
    t_word            r_s1_torque;
    t_word            r_s1_user;

    logic             r_s2_valid;
    logic [ModeW-1:0] r_s2_mode;
    logic             r_s2_calc;
    t_word            r_s2_torque;

    t_word r_tilt_angle;
    t_word r_tilt_rate;
    t_word r_held_torque;
    logic  r_running;

    logic  r_out_valid;
    t_word r_out_angle;
    t_word r_out_rate;
    logic  r_out_fell;

    logic w_in_xfer;
    logic w_s1_tick;
    logic w_s1_adv;
    logic w_s2_adv;
    logic w_s2_free;

    tsp_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (w_coefs)
    );

    tsp_mul_stage u_mul_stage (
        .i_clk        (i_clk),
        .i_load       (w_s1_adv),
        .i_coefs      (w_coefs),
        .i_angle      (r_tilt_angle),
        .i_rate       (r_tilt_rate),
        .i_torque     (r_held_torque),
        .i_user_angle (r_s1_user),
        .o_prod       (w_prod)
    );

    assign w_row0_prods[0] = w_prod[CoefA00];
    assign w_row0_prods[1] = w_prod[CoefA01];
    assign w_row0_prods[2] = w_prod[CoefB00];
    assign w_row0_prods[3] = w_prod[CoefB01];
    assign w_row1_prods[0] = w_prod[CoefA10];
    assign w_row1_prods[1] = w_prod[CoefA11];
    assign w_row1_prods[2] = w_prod[CoefB10];
    assign w_row1_prods[3] = w_prod[CoefB11];

    tsp_row_sum u_row_angle (
        .i_prod (w_row0_prods),
        .o_sum  (w_new_angle)
    );

    tsp_row_sum u_row_rate (
        .i_prod (w_row1_prods),
        .o_sum  (w_new_rate)
    );

    assign w_fall = (w_new_angle > FallLimit) || (w_new_angle < FallLimitNeg);

    // pipeline control; a tick only enters stage two once all earlier commands committed
    assign w_s2_adv  = r_s2_valid && (!r_s2_calc || !r_out_valid || o_res.ready);
    assign w_s2_free = !r_s2_valid || w_s2_adv;
    assign w_s1_tick = (r_s1_mode == MODE_TICK);
    assign w_s1_adv  = r_s1_valid && (w_s1_tick ? !r_s2_valid : w_s2_free);
    assign i_cmd.ready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer   = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_xfer) begin
            r_s1_mode   <= i_cmd.mode;
            r_s1_torque <= i_cmd.torque_value;
            r_s1_user   <= i_cmd.user_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_calc  <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= 1'b1;
            r_s2_calc  <= w_s1_tick && r_running;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
            r_s2_calc  <= 1'b0;
        end
        if (w_s1_adv) begin
            r_s2_mode   <= r_s1_mode;
            r_s2_torque <= r_s1_torque;
        end
    end

    // commit plant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_angle  <= '0;
            r_tilt_rate   <= '0;
            r_held_torque <= '0;
            r_running     <= 1'b0;
        end else if (w_s2_adv) begin
            case (r_s2_mode)
                MODE_TICK: begin
                    if (r_s2_calc) begin
                        if (w_fall) begin
                            r_tilt_angle  <= '0;
                            r_tilt_rate   <= '0;
                            r_held_torque <= '0;
                        end else begin
                            r_tilt_angle <= w_new_angle;
                            r_tilt_rate  <= w_new_rate;
                        end
                    end
                end
                MODE_LOAD_TORQUE: begin
                    r_held_torque <= r_s2_torque;
                end
                MODE_RESET: begin
                    r_tilt_angle  <= '0;
                    r_tilt_rate   <= '0;
                    r_held_torque <= '0;
                end
                MODE_START: begin
                    r_tilt_angle  <= '0;
                    r_tilt_rate   <= '0;
                    r_held_torque <= '0;
                    r_running     <= 1'b1;
                end
                MODE_STOP: begin
                    r_running <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_adv && r_s2_calc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s2_adv && r_s2_calc) begin
            r_out_angle <= w_new_angle;
            r_out_rate  <= w_new_rate;
            r_out_fell  <= w_fall;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.angle_out = r_out_angle;
    assign o_res.rate_out  = r_out_rate;
    assign o_res.fell      = r_out_fell;

    a_tick_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_s1_tick) |-> !r_s2_valid)
        else $error("tick entered stage two before the previous command committed");

    a_fall_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_adv && r_s2_calc && w_fall) |=>
        (r_tilt_angle == '0 && r_tilt_rate == '0 && r_held_torque == '0))
        else $error("plant state not cleared after a fall");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_adv && r_s2_calc) |-> (!r_out_valid || o_res.ready))
        else $error("pending result overwritten");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_adv && r_s2_mode == MODE_STOP) |=> !r_running)
        else $error("run flag still set after stop");

endmodule

### bench/two_state_plant_model_step_test.sv
// ----------------------------------------------------------------------------
// two_state_plant_model_step_test: self-checking bench of the two-state plant
// Drives plant commands over the command channel against a local Q8.24 model
// of the angle/rate update and compares every result transfer with it. A
// directed table covers every command, the field extremes, the fall limits and
// the relative-angle saturation. It is followed by random phases across
// several coefficient banks, with bursts of idling on both channels and one
// long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_state_plant_model_step_test
    import tsp_pkg::*;
();

    localparam int unsigned NumRows        = 26;
    localparam int unsigned PassFrom       = 19;
    localparam int unsigned NumPhases      = 6;
    localparam int unsigned ItemsPerPhase  = 305;
    localparam int unsigned HoldAfter      = 100;
    localparam int unsigned HoldCycles     = 300;
    localparam int unsigned SettleCycles   = 8;
    localparam int unsigned CycleLimit     = 400000;
    localparam int unsigned SmallSpan      = 1 << 25;
    localparam int unsigned CoefSpan       = 1 << 28;

    localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
    localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

    localparam t_word WordMax = 32'sh7FFF_FFFF;
    localparam t_word WordMin = 32'sh8000_0000;
    localparam t_word One24   = 32'sd16777216;
    localparam t_word One30   = 32'sd1073741824;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        t_word            torque;
        t_word            user;
    } t_cmd;

    typedef struct packed {
        t_word angle;
        t_word rate;
        logic  fell;
    } t_plant_res;

    typedef struct packed {
        t_cmd       cmd;
        logic       typed;
        t_plant_res want;
    } t_row;

    localparam t_plant_res NoRes   = '0;
    localparam t_plant_res ZeroRes = '{32'sd0, 32'sd0, 1'b0};

    localparam t_row DirectedRows [NumRows] = '{
        '{'{MODE_TICK, 32'sd0, 32'sd0}, 1'b0, NoRes},
        '{'{MODE_START, WordMax, WordMin}, 1'b0, NoRes},
        '{'{MODE_TICK, WordMin, 32'sd0}, 1'b1, ZeroRes},
        '{'{MODE_LOAD_TORQUE, WordMax, 32'sd0}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, WordMax}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, WordMin}, 1'b0, NoRes},
        '{'{MODE_LOAD_TORQUE, WordMin, WordMax}, 1'b0, NoRes},
        '{'{MODE_TICK, WordMax, 32'sd0}, 1'b0, NoRes},
        '{'{ModeSpare5, WordMax, WordMax}, 1'b0, NoRes},
        '{'{MODE_STOP, 32'sd0, 32'sd0}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, One24}, 1'b0, NoRes},
        '{'{MODE_RESET, WordMin, WordMin}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, One24}, 1'b0, NoRes},
        '{'{MODE_START, 32'sd0, 32'sd0}, 1'b0, NoRes},
        '{'{ModeSpare7, WordMin, WordMin}, 1'b0, NoRes},
        '{'{MODE_TICK, WordMax, 32'sd0}, 1'b1, ZeroRes},
        '{'{MODE_TICK, 32'sd0, One24}, 1'b0, NoRes},
        '{'{MODE_RESET, WordMax, WordMax}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, -One24}, 1'b0, NoRes},
        '{'{MODE_START, 32'sd0, 32'sd0}, 1'b0, NoRes},
        '{'{MODE_TICK, 32'sd0, FallLimit}, 1'b1, '{FallLimit, 32'sd0, 1'b0}},
        '{'{MODE_TICK, 32'sd0, FallLimit + 32'sd1}, 1'b1,
          '{FallLimit + 32'sd1, 32'sd0, 1'b1}},
        '{'{MODE_TICK, 32'sd0, FallLimitNeg}, 1'b1, '{FallLimitNeg, 32'sd0, 1'b0}},
        '{'{MODE_TICK, 32'sd0, FallLimitNeg - 32'sd1}, 1'b1,
          '{FallLimitNeg - 32'sd1, 32'sd0, 1'b1}},
        '{'{MODE_TICK, 32'sd0, FallLimit}, 1'b1, '{FallLimit, 32'sd0, 1'b0}},
        '{'{MODE_TICK, 32'sd0, WordMin}, 1'b1, '{FallLimit + WordMin, 32'sd0, 1'b1}}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CoefIdxW-1:0] cfg_index;
    t_word               cfg_data;

    tsp_cmd_if cmd_bus ();
    tsp_res_if res_bus ();

    two_state_plant_model_step u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    t_word       coef_model [NumCoefs];
    t_word       plant_angle;
    t_word       plant_rate;
    t_word       plant_torque;
    bit          plant_running;
    t_plant_res  plant_outputs_due [$];
    t_plant_res  due_state;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          idling;
    bit          hold_request;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Q2.30 x Q8.24 row: exact sum, round half up, saturate
    function automatic t_word row_sum(input t_word ca, input t_word cr, input t_word ct,
                                      input t_word cu, input t_word angle, input t_word rate,
                                      input t_word torque, input t_word rel);
        logic signed [66:0] acc;
        logic signed [66:0] scaled;
        acc = ca * angle + cr * rate + ct * torque + cu * rel + (67'sd1 <<< (FracShift - 1));
        scaled = acc >>> FracShift;
        if (scaled > WordMax) begin
            return WordMax;
        end
        if (scaled < WordMin) begin
            return WordMin;
        end
        return scaled[DataW-1:0];
    endfunction

    function automatic bit advance_plant(input t_cmd c, output t_plant_res r);
        logic signed [DataW:0] diff;
        t_word                 rel;
        t_word                 na;
        t_word                 nr;
        r = '0;
        case (c.mode)
            MODE_LOAD_TORQUE: begin
                plant_torque = c.torque;
                return 1'b0;
            end
            MODE_RESET, MODE_START: begin
                plant_angle  = '0;
                plant_rate   = '0;
                plant_torque = '0;
                if (c.mode == MODE_START) begin
                    plant_running = 1'b1;
                end
                return 1'b0;
            end
            MODE_STOP: begin
                plant_running = 1'b0;
                return 1'b0;
            end
            MODE_TICK: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        if (!plant_running) begin
            return 1'b0;
        end
        diff = c.user - plant_angle;
        if (diff > WordMax) begin
            rel = WordMax;
        end else if (diff < WordMin) begin
            rel = WordMin;
        end else begin
            rel = diff[DataW-1:0];
        end
        na = row_sum(coef_model[CoefA00], coef_model[CoefA01], coef_model[CoefB00],
                     coef_model[CoefB01], plant_angle, plant_rate, plant_torque, rel);
        nr = row_sum(coef_model[CoefA10], coef_model[CoefA11], coef_model[CoefB10],
                     coef_model[CoefB11], plant_angle, plant_rate, plant_torque, rel);
        r.angle = na;
        r.rate  = nr;
        r.fell  = (na > FallLimit) || (na < FallLimitNeg);
        plant_angle = na;
        plant_rate  = nr;
        if (r.fell) begin
            plant_angle  = '0;
            plant_rate   = '0;
            plant_torque = '0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (plant_outputs_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result angle %0d rate %0d fell %0b",
                                        res_bus.angle_out, res_bus.rate_out, res_bus.fell));
            end else begin
                due_state = plant_outputs_due.pop_front();
                if (res_bus.angle_out !== due_state.angle) begin
                    flag_mismatch($sformatf("angle got %0d want %0d",
                                            res_bus.angle_out, due_state.angle));
                end
                if (res_bus.rate_out !== due_state.rate) begin
                    flag_mismatch($sformatf("rate got %0d want %0d",
                                            res_bus.rate_out, due_state.rate));
                end
                if (res_bus.fell !== due_state.fell) begin
                    flag_mismatch($sformatf("fell got %0b want %0b",
                                            res_bus.fell, due_state.fell));
                end
            end
        end
    end

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left != 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HoldCycles - 1;
                res_bus.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input bit typed, input t_plant_res typed_res);
        t_plant_res pred;
        if (idling && $urandom_range(0, 3) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.mode         <= c.mode;
        cmd_bus.torque_value <= c.torque;
        cmd_bus.user_angle   <= c.user;
        @(posedge clk);
        while (!cmd_bus.ready) begin
            @(posedge clk);
        end
        if (advance_plant(c, pred)) begin
            plant_outputs_due.push_back(typed ? typed_res : pred);
        end
    endtask

    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (plant_outputs_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic load_coefs(input t_coef_bank bank);
        int unsigned k;
        for (k = 0; k < NumCoefs; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CoefIdxW'(k);
            cfg_data  <= bank[k];
            @(posedge clk);
            coef_model[k] = bank[k];
        end
        cfg_we <= 1'b0;
    endtask

    function automatic t_word pick_word();
        if ($urandom_range(0, 3) == 0) begin
            return t_word'($urandom);
        end
        return t_word'($urandom_range(0, 2 * SmallSpan)) - t_word'(SmallSpan);
    endfunction

    initial begin
        int unsigned i;
        int unsigned k;
        int unsigned phase;
        int unsigned counted;
        int unsigned pick;
        bit          hold_done;
        t_cmd        c;
        t_coef_bank  bank;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.mode         <= MODE_TICK;
        cmd_bus.torque_value <= '0;
        cmd_bus.user_angle   <= '0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        idling       = 1'b1;
        coef_model    = CoefReset;
        plant_angle   = '0;
        plant_rate    = '0;
        plant_torque  = '0;
        plant_running = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NumRows; i++) begin
            if (i == PassFrom) begin
                // angle follows the user angle, rate stays at zero
                settle();
                bank = '{default: '0};
                bank[CoefA00] = One30;
                bank[CoefB01] = One30;
                load_coefs(bank);
            end
            send_cmd(DirectedRows[i].cmd, DirectedRows[i].typed, DirectedRows[i].want);
        end

        for (phase = 0; phase < NumPhases; phase++) begin
            settle();
            for (k = 0; k < NumCoefs; k++) begin
                case (phase)
                    0, 5: begin
                        bank[k] = CoefReset[k];
                    end
                    1: begin
                        bank[k] = WordMax;
                    end
                    2: begin
                        bank[k] = WordMin;
                    end
                    3: begin
                        bank[k] = t_word'($urandom);
                    end
                    default: begin
                        pick = $urandom_range(0, 2);
                        bank[k] = (pick == 0) ? WordMax : (pick == 1) ? WordMin :
                                  t_word'($urandom_range(0, 2 * CoefSpan)) - t_word'(CoefSpan);
                    end
                endcase
            end
            load_coefs(bank);
            idling = (phase != NumPhases - 1);
            counted = 0;
            while (counted < ItemsPerPhase) begin
                pick = $urandom_range(0, 99);
                c.torque = pick_word();
                c.user   = pick_word();
                if (!plant_running && pick < 40) begin
                    c.mode = MODE_START;
                end else if (pick < 70) begin
                    c.mode = MODE_TICK;
                end else if (pick < 80) begin
                    c.mode = MODE_LOAD_TORQUE;
                end else if (pick < 85) begin
                    c.mode = MODE_START;
                end else if (pick < 89) begin
                    c.mode = MODE_RESET;
                end else if (pick < 94) begin
                    c.mode = MODE_STOP;
                end else begin
                    c.mode = ModeSpare5 + ModeW'($urandom_range(0, ModeSpare7 - ModeSpare5));
                end
                counted++;
                if (phase == 0 && counted == HoldAfter && !hold_done) begin
                    hold_done = 1'b1;
                    hold_request = 1'b1;
                end
                send_cmd(c, 1'b0, NoRes);
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
